>>> rtl/csrgb_pkg.sv
package csrgb_pkg;

  // field widths of the item and result channels, the config registers and the APB bus
  localparam int OP_W     = 2;
  localparam int VERT_W   = 10;
  localparam int DEG_W    = 13;
  localparam int WEIGHT_W = 64;
  localparam int VALUE_W  = 13;
  localparam int STAT_W   = 2;
  localparam int VC_W     = 11;
  localparam int ET_W     = 13;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEGREE = 2'd1;
  localparam logic [OP_W-1:0] OP_EDGE   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_EDGE_TOTAL   = 2'd1;
  localparam logic [1:0] REG_WEIGHTED     = 2'd2;

  typedef struct packed {
    logic [VC_W-1:0] vertex_count;
    logic [ET_W-1:0] edge_total;
    logic            weighted;
  } cfg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_PS_RD,
    S_PS_WR,
    S_EDGE_RD,
    S_EDGE_WR,
    S_DONE
  } state_t;

endpackage

>>> rtl/csrgb_regs.sv
module csrgb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csrgb_pkg::PADDR_W-1:0] paddr,
  input  logic [csrgb_pkg::PDATA_W-1:0] pwdata,
  output logic [csrgb_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output csrgb_pkg::cfg_t               cfg
);

  csrgb_pkg::cfg_t cfg_r, cfg_nxt;
  logic [1:0]      reg_idx;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        csrgb_pkg::REG_VERTEX_COUNT: cfg_nxt.vertex_count = pwdata[csrgb_pkg::VC_W-1:0];
        csrgb_pkg::REG_EDGE_TOTAL:   cfg_nxt.edge_total   = pwdata[csrgb_pkg::ET_W-1:0];
        csrgb_pkg::REG_WEIGHTED:     cfg_nxt.weighted     = pwdata[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      csrgb_pkg::REG_VERTEX_COUNT: prdata = csrgb_pkg::PDATA_W'(cfg_r.vertex_count);
      csrgb_pkg::REG_EDGE_TOTAL:   prdata = csrgb_pkg::PDATA_W'(cfg_r.edge_total);
      csrgb_pkg::REG_WEIGHTED:     prdata = csrgb_pkg::PDATA_W'(cfg_r.weighted);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/csrgb_offset_mem.sv
module csrgb_offset_mem #(
  parameter int DEPTH = 1026,
  parameter int AW    = 11,
  parameter int DW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> rtl/csrgb_edge_mem.sv
module csrgb_edge_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                                  clk,
  input  logic                                  edge_we,
  input  logic                                  weight_we,
  input  logic [AW-1:0]                         addr,
  input  logic [csrgb_pkg::VERT_W-1:0]          target,
  input  logic signed [csrgb_pkg::WEIGHT_W-1:0] weight
);

  // slot stores for edge targets and weights
  logic [csrgb_pkg::VERT_W-1:0]   tgt_mem [DEPTH];
  logic [csrgb_pkg::WEIGHT_W-1:0] wgt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (edge_we) begin
      tgt_mem[addr] <= target;
    end
    if (edge_we && weight_we) begin
      wgt_mem[addr] <= weight;
    end
  end

endmodule

>>> rtl/csrgb_ctrl.sv
module csrgb_ctrl #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int VAW          = 11,
  parameter int CW           = 11,
  parameter int OW           = 13,
  parameter int EAW          = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  csrgb_pkg::cfg_t                       cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [csrgb_pkg::OP_W-1:0]            in_operation,
  input  logic [csrgb_pkg::VERT_W-1:0]          in_vertex,
  input  logic [csrgb_pkg::DEG_W-1:0]           in_degree,
  input  logic [csrgb_pkg::VERT_W-1:0]          in_target,
  input  logic signed [csrgb_pkg::WEIGHT_W-1:0] in_edge_weight,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [csrgb_pkg::VALUE_W-1:0]         out_value,
  output logic [csrgb_pkg::STAT_W-1:0]          out_status,
  output logic                                  off_we,
  output logic [VAW-1:0]                        off_waddr,
  output logic [OW-1:0]                         off_wdata,
  output logic                                  off_re,
  output logic [VAW-1:0]                        off_raddr,
  input  logic [OW-1:0]                         off_rdata,
  output logic                                  edge_we,
  output logic                                  weight_we,
  output logic [EAW-1:0]                        edge_addr,
  output logic [csrgb_pkg::VERT_W-1:0]          edge_target,
  output logic signed [csrgb_pkg::WEIGHT_W-1:0] edge_weight
);

  localparam int IW = (VAW > csrgb_pkg::VERT_W) ? VAW : csrgb_pkg::VERT_W;
  localparam logic [VAW-1:0] LAST_ENTRY = VAW'(MAX_VERTICES + 1);

  csrgb_pkg::state_t state_r, state_nxt;
  logic [VAW-1:0]    cnt_r, cnt_nxt;
  logic [OW-1:0]     acc_r, acc_nxt;
  logic              built_r, built_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [csrgb_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [csrgb_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [csrgb_pkg::VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [csrgb_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;

  logic [csrgb_pkg::OP_W-1:0]            item_op_r, item_op_nxt;
  logic [csrgb_pkg::VERT_W-1:0]          item_vertex_r, item_vertex_nxt;
  logic [csrgb_pkg::DEG_W-1:0]           item_degree_r, item_degree_nxt;
  logic [csrgb_pkg::VERT_W-1:0]          item_target_r, item_target_nxt;
  logic signed [csrgb_pkg::WEIGHT_W-1:0] item_weight_r, item_weight_nxt;

  logic [CW-1:0] eff_n;
  logic [OW-1:0] eff_e;
  logic          v_ok, t_ok;
  logic [IW:0]   v_plus1, v_plus2;
  logic [OW:0]   psum;
  logic [OW-1:0] psum_sat;
  logic          ps_last;

  assign eff_n = (CW'(cfg.vertex_count) < CW'(MAX_VERTICES)) ?
                 CW'(cfg.vertex_count) : CW'(MAX_VERTICES);
  assign eff_e = (OW'(cfg.edge_total) < OW'(MAX_EDGES)) ?
                 OW'(cfg.edge_total) : OW'(MAX_EDGES);
  assign v_ok  = CW'(item_vertex_r) < eff_n;
  assign t_ok  = CW'(item_target_r) < eff_n;

  // entry v+2 holds the degree, entry v+1 the cursor once built
  assign v_plus1 = (IW+1)'(item_vertex_r) + (IW+1)'(1);
  assign v_plus2 = (IW+1)'(item_vertex_r) + (IW+1)'(2);

  assign psum     = (OW+1)'(off_rdata) + (OW+1)'(acc_r);
  assign psum_sat = (psum > (OW+1)'(MAX_EDGES)) ? OW'(MAX_EDGES) : psum[OW-1:0];
  assign ps_last  = (CW+1)'(cnt_r) == ((CW+1)'(eff_n) + (CW+1)'(1));

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_status  = out_status_r;
  assign edge_target = item_target_r;
  assign edge_weight = item_weight_r;
  assign edge_addr   = off_rdata[EAW-1:0];

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    acc_nxt         = acc_r;
    built_nxt       = built_r;
    res_value_nxt   = res_value_r;
    res_status_nxt  = res_status_r;
    item_op_nxt     = item_op_r;
    item_vertex_nxt = item_vertex_r;
    item_degree_nxt = item_degree_r;
    item_target_nxt = item_target_r;
    item_weight_nxt = item_weight_r;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    in_ready        = 1'b0;
    off_we          = 1'b0;
    off_waddr       = cnt_r;
    off_wdata       = '0;
    off_re          = 1'b0;
    off_raddr       = cnt_r;
    edge_we         = 1'b0;
    weight_we       = 1'b0;

    case (state_r)
      csrgb_pkg::S_INIT, csrgb_pkg::S_CLEAR: begin
        // zero sweep over the whole offset store
        off_we = 1'b1;
        if (cnt_r == LAST_ENTRY) begin
          cnt_nxt = '0;
          if (state_r == csrgb_pkg::S_INIT) begin
            state_nxt = csrgb_pkg::S_IDLE;
          end else begin
            res_value_nxt  = '0;
            res_status_nxt = csrgb_pkg::STAT_OK;
            state_nxt      = csrgb_pkg::S_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + VAW'(1);
        end
      end

      csrgb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_op_nxt     = in_operation;
          item_vertex_nxt = in_vertex;
          item_degree_nxt = in_degree;
          item_target_nxt = in_target;
          item_weight_nxt = in_edge_weight;
          state_nxt       = csrgb_pkg::S_DECODE;
        end
      end

      csrgb_pkg::S_DECODE: begin
        case (item_op_r)
          csrgb_pkg::OP_CLEAR: begin
            cnt_nxt   = '0;
            built_nxt = 1'b0;
            state_nxt = csrgb_pkg::S_CLEAR;
          end
          csrgb_pkg::OP_DEGREE: begin
            if (v_ok) begin
              off_we         = 1'b1;
              off_waddr      = v_plus2[VAW-1:0];
              off_wdata      = OW'(item_degree_r);
              res_value_nxt  = item_degree_r;
              res_status_nxt = csrgb_pkg::STAT_OK;
            end else begin
              res_value_nxt  = '0;
              res_status_nxt = csrgb_pkg::STAT_RANGE;
            end
            state_nxt = csrgb_pkg::S_DONE;
          end
          csrgb_pkg::OP_EDGE: begin
            if (!built_r) begin
              cnt_nxt   = VAW'(1);
              acc_nxt   = '0;
              state_nxt = csrgb_pkg::S_PS_RD;
            end else begin
              state_nxt = csrgb_pkg::S_EDGE_RD;
            end
          end
          default: begin
            res_value_nxt  = '0;
            res_status_nxt = csrgb_pkg::STAT_OK;
            state_nxt      = csrgb_pkg::S_DONE;
          end
        endcase
      end

      csrgb_pkg::S_PS_RD: begin
        off_re    = 1'b1;
        state_nxt = csrgb_pkg::S_PS_WR;
      end

      csrgb_pkg::S_PS_WR: begin
        off_we    = 1'b1;
        off_wdata = psum_sat;
        acc_nxt   = psum_sat;
        if (ps_last) begin
          built_nxt = 1'b1;
          state_nxt = csrgb_pkg::S_EDGE_RD;
        end else begin
          cnt_nxt   = cnt_r + VAW'(1);
          state_nxt = csrgb_pkg::S_PS_RD;
        end
      end

      csrgb_pkg::S_EDGE_RD: begin
        if (v_ok && t_ok) begin
          off_re    = 1'b1;
          off_raddr = v_plus1[VAW-1:0];
          state_nxt = csrgb_pkg::S_EDGE_WR;
        end else begin
          res_value_nxt  = '0;
          res_status_nxt = csrgb_pkg::STAT_RANGE;
          state_nxt      = csrgb_pkg::S_DONE;
        end
      end

      csrgb_pkg::S_EDGE_WR: begin
        if (off_rdata >= eff_e) begin
          res_value_nxt  = '0;
          res_status_nxt = csrgb_pkg::STAT_OVERFLOW;
        end else begin
          off_we         = 1'b1;
          off_waddr      = v_plus1[VAW-1:0];
          off_wdata      = off_rdata + OW'(1);
          edge_we        = 1'b1;
          weight_we      = cfg.weighted;
          res_value_nxt  = off_rdata[csrgb_pkg::VALUE_W-1:0];
          res_status_nxt = csrgb_pkg::STAT_OK;
        end
        state_nxt = csrgb_pkg::S_DONE;
      end

      csrgb_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = csrgb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = csrgb_pkg::S_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csrgb_pkg::S_INIT;
      cnt_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r         <= acc_nxt;
    res_value_r   <= res_value_nxt;
    res_status_r  <= res_status_nxt;
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
    item_op_r     <= item_op_nxt;
    item_vertex_r <= item_vertex_nxt;
    item_degree_r <= item_degree_nxt;
    item_target_r <= item_target_nxt;
    item_weight_r <= item_weight_nxt;
  end

endmodule

>>> rtl/csr_graph_builder.sv
// channel   | direction | handshake             | payload
// in_       | input     | in_valid / in_ready   | operation, vertex, degree, target, edge_weight
// out_      | output    | out_valid / out_ready | value, status
// apb       | input     | psel, penable, pready | paddr, pwdata, prdata
//
// one item at a time: each item passes decode and the result load; an edge item also
// passes the cursor read-modify-write in the offset store between the two.
// the first edge item after a clear or reset adds a prefix sum over the offset store.
// a clear item and reset both sweep the offset store, one entry a cycle;
// no item is accepted during the sweep after reset.
// a result held on a stalled out_ channel does not block the next item's accept.
module csr_graph_builder #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [csrgb_pkg::OP_W-1:0]            in_operation,
  input  logic [csrgb_pkg::VERT_W-1:0]          in_vertex,
  input  logic [csrgb_pkg::DEG_W-1:0]           in_degree,
  input  logic [csrgb_pkg::VERT_W-1:0]          in_target,
  input  logic signed [csrgb_pkg::WEIGHT_W-1:0] in_edge_weight,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [csrgb_pkg::VALUE_W-1:0]         out_value,
  output logic [csrgb_pkg::STAT_W-1:0]          out_status,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csrgb_pkg::PADDR_W-1:0]         paddr,
  input  logic [csrgb_pkg::PDATA_W-1:0]         pwdata,
  output logic [csrgb_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready
);

  localparam int OFF_DEPTH = MAX_VERTICES + 2;
  localparam int VAW = $clog2(OFF_DEPTH);
  localparam int CW  = ($clog2(MAX_VERTICES + 1) > csrgb_pkg::VC_W) ?
                       $clog2(MAX_VERTICES + 1) : csrgb_pkg::VC_W;
  localparam int OW  = ($clog2(MAX_EDGES + 1) > csrgb_pkg::DEG_W) ?
                       $clog2(MAX_EDGES + 1) : csrgb_pkg::DEG_W;
  localparam int EAW = $clog2(MAX_EDGES);

  csrgb_pkg::cfg_t cfg;

  logic           off_we, off_re;
  logic [VAW-1:0] off_waddr, off_raddr;
  logic [OW-1:0]  off_wdata, off_rdata;

  logic                                  edge_we, weight_we;
  logic [EAW-1:0]                        edge_addr;
  logic [csrgb_pkg::VERT_W-1:0]          edge_target;
  logic signed [csrgb_pkg::WEIGHT_W-1:0] edge_weight;

  csrgb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csrgb_offset_mem #(
    .DEPTH (OFF_DEPTH),
    .AW    (VAW),
    .DW    (OW)
  ) u_offset_mem (
    .clk   (clk),
    .we    (off_we),
    .waddr (off_waddr),
    .wdata (off_wdata),
    .re    (off_re),
    .raddr (off_raddr),
    .rdata (off_rdata)
  );

  csrgb_edge_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (EAW)
  ) u_edge_mem (
    .clk       (clk),
    .edge_we   (edge_we),
    .weight_we (weight_we),
    .addr      (edge_addr),
    .target    (edge_target),
    .weight    (edge_weight)
  );

  csrgb_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .VAW          (VAW),
    .CW           (CW),
    .OW           (OW),
    .EAW          (EAW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_vertex      (in_vertex),
    .in_degree      (in_degree),
    .in_target      (in_target),
    .in_edge_weight (in_edge_weight),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_status     (out_status),
    .off_we         (off_we),
    .off_waddr      (off_waddr),
    .off_wdata      (off_wdata),
    .off_re         (off_re),
    .off_raddr      (off_raddr),
    .off_rdata      (off_rdata),
    .edge_we        (edge_we),
    .weight_we      (weight_we),
    .edge_addr      (edge_addr),
    .edge_target    (edge_target),
    .edge_weight    (edge_weight)
  );

endmodule

>>> rtl/csrgb_checker.sv
module csrgb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [csrgb_pkg::VALUE_W-1:0] out_value,
  input logic [csrgb_pkg::STAT_W-1:0]  out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

  // flagged items carry a zero value
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != csrgb_pkg::STAT_OK) |-> out_value == '0)
    else $error("flagged result with nonzero value");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is at work");

  // the store sweep after reset keeps the input closed
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid right after reset");

endmodule

bind csr_graph_builder csrgb_checker u_csrgb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .out_status (out_status)
);
